/* hdl/pcdt_pkg.sv */
// Shared types and constants for the per-process call depth tracker.
// No dependencies; used by the controller, datapath and top level.
package pcdt_pkg;

    localparam logic [1:0] ST_OTHER     = 2'd0;
    localparam logic [1:0] ST_RECORD    = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_BAD_VER   = 2'd3;

    localparam int IN_PID_W   = 32;
    localparam int IN_USER_W  = 3;
    localparam int OUT_FIELD_W = 32;
    localparam int OUT_SLOT_W = 4;
    localparam int OUT_PCNT_W = 5;
    localparam int OUT_USER_W = 2;
    localparam int OUT_DATA_W = 272;

    localparam int OFF_SLOT      = 0;
    localparam int OFF_DEPTH     = OFF_SLOT + OUT_SLOT_W;
    localparam int OFF_INDENT    = OFF_DEPTH + OUT_FIELD_W;
    localparam int OFF_DEEPEST   = OFF_INDENT + OUT_FIELD_W;
    localparam int OFF_UNMATCHED = OFF_DEEPEST + OUT_FIELD_W;
    localparam int OFF_RECORDS   = OFF_UNMATCHED + OUT_FIELD_W;
    localparam int OFF_SKIPPED   = OFF_RECORDS + OUT_FIELD_W;
    localparam int OFF_MALFORMED = OFF_SKIPPED + OUT_FIELD_W;
    localparam int OFF_BAD_VER   = OFF_MALFORMED + OUT_FIELD_W;
    localparam int OFF_PCOUNT    = OFF_BAD_VER + OUT_FIELD_W;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic is_record;
        logic last_idx;
        logic out_free;
    } t_dp_status;

endpackage

/* hdl/pcdt_ram.sv */
// Generic simple dual-port RAM with registered read.
// No dependencies.
module pcdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/pcdt_ctrl.sv */
// Sequencer for the tracker: accept, slot scan, drain, commit.
// Depends on pcdt_pkg for the command and status structs.
module pcdt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  pcdt_pkg::t_dp_status i_status,
    output pcdt_pkg::t_ctl_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_status.is_record) begin
                    n_state = S_UPDATE;
                end else begin
                    o_cmd.issue = 1'b1;
                    if (i_status.last_idx) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

/* hdl/pcdt_datapath.sv */
// Datapath: input capture, slot table, match and free search, update, output register.
// Depends on pcdt_pkg and pcdt_ram.
module pcdt_datapath #(
    parameter int PROCESS_SLOTS = 16,
    parameter int COUNTER_BITS  = 32,
    parameter int PID_BITS      = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [pcdt_pkg::IN_PID_W-1:0]       i_s_tdata,
    input  logic [pcdt_pkg::IN_USER_W-1:0]      i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [pcdt_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic [pcdt_pkg::OUT_USER_W-1:0]     o_m_tuser,
    input  pcdt_pkg::t_ctl_cmd                  i_cmd,
    output pcdt_pkg::t_dp_status                o_status
);

    localparam int SW = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
    localparam int CW = $clog2(PROCESS_SLOTS + 1);
    localparam int CB = COUNTER_BITS;
    localparam int PW = (PID_BITS < pcdt_pkg::IN_PID_W) ? PID_BITS : pcdt_pkg::IN_PID_W;
    localparam int RW = PW + 3 * CB;
    localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        return (v == CNT_MAX) ? v : v + CB'(1);
    endfunction

    logic [1:0]          r_status;
    logic [PW-1:0]       r_pid;
    logic                r_exit;
    logic [SW-1:0]       r_idx;
    logic                r_pend;
    logic [SW-1:0]       r_pend_idx;
    logic                r_found;
    logic [SW-1:0]       r_slot;
    logic [CB-1:0]       r_hit_depth;
    logic [CB-1:0]       r_hit_deep;
    logic [CB-1:0]       r_hit_unm;
    logic                r_free_ok;
    logic [SW-1:0]       r_free_idx;
    logic [PROCESS_SLOTS-1:0] r_used;
    logic [CW-1:0]       r_inuse;
    logic [CB-1:0]       r_rec;
    logic [CB-1:0]       r_skip;
    logic [CB-1:0]       r_mal;
    logic [CB-1:0]       r_bad;
    logic                r_out_valid;
    logic [pcdt_pkg::OUT_USER_W-1:0] r_out_user;
    logic [pcdt_pkg::OUT_DATA_W-1:0] r_out_data;

    logic [RW-1:0]       w_rdata;
    logic [RW-1:0]       w_wdata;
    logic [PW-1:0]       w_rd_pid;
    logic                w_hit;
    logic                w_free;
    logic                w_record;
    logic                w_taken;
    logic                w_full;
    logic                w_alloc;
    logic [SW-1:0]       w_slot;
    logic [CB-1:0]       w_depth;
    logic [CB-1:0]       w_deep;
    logic [CB-1:0]       w_unm;
    logic [CB-1:0]       n_depth;
    logic [CB-1:0]       n_deep;
    logic [CB-1:0]       n_unm;
    logic [CB-1:0]       w_indent;
    logic [CB-1:0]       n_rec;
    logic [CB-1:0]       n_skip;
    logic [CB-1:0]       n_mal;
    logic [CB-1:0]       n_bad;
    logic [CW-1:0]       n_inuse;
    logic [pcdt_pkg::OUT_DATA_W-1:0] n_out_data;

    pcdt_ram #(
        .WIDTH (RW),
        .DEPTH (PROCESS_SLOTS),
        .AW    (SW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit & w_taken),
        .i_waddr (w_slot),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_rd_pid = w_rdata[3*CB +: PW];
    assign w_hit    = r_pend && r_used[r_pend_idx] && (w_rd_pid == r_pid);
    assign w_free   = r_pend && !r_used[r_pend_idx] && !r_free_ok;

    assign w_record = (r_status == pcdt_pkg::ST_RECORD);
    assign w_alloc  = w_record && !r_found && r_free_ok;
    assign w_taken  = w_record && (r_found || r_free_ok);
    assign w_full   = w_record && !w_taken;
    assign w_slot   = r_found ? r_slot : r_free_idx;

    assign w_depth = r_found ? r_hit_depth : '0;
    assign w_deep  = r_found ? r_hit_deep  : '0;
    assign w_unm   = r_found ? r_hit_unm   : '0;

    always_comb begin
        n_depth = w_depth;
        n_deep  = w_deep;
        n_unm   = w_unm;
        if (!r_exit) begin
            n_depth = sat_inc(w_depth);
            if (n_depth > w_deep) begin
                n_deep = n_depth;
            end
        end else if (w_depth == '0) begin
            n_unm = sat_inc(w_unm);
        end else begin
            n_depth = w_depth - CB'(1);
        end
        if (n_depth == '0) begin
            w_indent = '0;
        end else if (r_exit) begin
            w_indent = n_depth;
        end else begin
            w_indent = n_depth - CB'(1);
        end
    end

    assign w_wdata = {r_pid, n_depth, n_deep, n_unm};

    assign n_rec   = w_taken ? sat_inc(r_rec) : r_rec;
    assign n_skip  = (r_status == pcdt_pkg::ST_OTHER) ? sat_inc(r_skip) : r_skip;
    assign n_mal   = (r_status == pcdt_pkg::ST_MALFORMED) ? sat_inc(r_mal) : r_mal;
    assign n_bad   = (r_status == pcdt_pkg::ST_BAD_VER) ? sat_inc(r_bad) : r_bad;
    assign n_inuse = w_alloc ? r_inuse + CW'(1) : r_inuse;

    always_comb begin
        n_out_data = '0;
        if (w_taken) begin
            n_out_data[pcdt_pkg::OFF_SLOT +: pcdt_pkg::OUT_SLOT_W] =
                pcdt_pkg::OUT_SLOT_W'(w_slot);
            n_out_data[pcdt_pkg::OFF_DEPTH +: pcdt_pkg::OUT_FIELD_W] =
                pcdt_pkg::OUT_FIELD_W'(n_depth);
            n_out_data[pcdt_pkg::OFF_INDENT +: pcdt_pkg::OUT_FIELD_W] =
                pcdt_pkg::OUT_FIELD_W'(w_indent);
            n_out_data[pcdt_pkg::OFF_DEEPEST +: pcdt_pkg::OUT_FIELD_W] =
                pcdt_pkg::OUT_FIELD_W'(n_deep);
            n_out_data[pcdt_pkg::OFF_UNMATCHED +: pcdt_pkg::OUT_FIELD_W] =
                pcdt_pkg::OUT_FIELD_W'(n_unm);
        end
        n_out_data[pcdt_pkg::OFF_RECORDS +: pcdt_pkg::OUT_FIELD_W] =
            pcdt_pkg::OUT_FIELD_W'(n_rec);
        n_out_data[pcdt_pkg::OFF_SKIPPED +: pcdt_pkg::OUT_FIELD_W] =
            pcdt_pkg::OUT_FIELD_W'(n_skip);
        n_out_data[pcdt_pkg::OFF_MALFORMED +: pcdt_pkg::OUT_FIELD_W] =
            pcdt_pkg::OUT_FIELD_W'(n_mal);
        n_out_data[pcdt_pkg::OFF_BAD_VER +: pcdt_pkg::OUT_FIELD_W] =
            pcdt_pkg::OUT_FIELD_W'(n_bad);
        n_out_data[pcdt_pkg::OFF_PCOUNT +: pcdt_pkg::OUT_PCNT_W] =
            pcdt_pkg::OUT_PCNT_W'(n_inuse);
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_free_ok   <= 1'b0;
            r_used      <= '0;
            r_inuse     <= '0;
            r_rec       <= '0;
            r_skip      <= '0;
            r_mal       <= '0;
            r_bad       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= i_cmd.issue;
            if (i_cmd.load) begin
                r_found   <= 1'b0;
                r_free_ok <= 1'b0;
            end else begin
                if (w_hit && !r_found) begin
                    r_found <= 1'b1;
                end
                if (w_free) begin
                    r_free_ok <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_rec       <= n_rec;
                r_skip      <= n_skip;
                r_mal       <= n_mal;
                r_bad       <= n_bad;
                r_inuse     <= n_inuse;
                if (w_alloc) begin
                    r_used[w_slot] <= 1'b1;
                end
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status <= i_s_tuser[1:0];
            r_exit   <= i_s_tuser[2];
            r_pid    <= PW'(i_s_tdata);
            r_idx    <= '0;
        end else if (i_cmd.issue) begin
            r_idx <= r_idx + SW'(1);
        end
        r_pend_idx <= r_idx;
        if (w_hit && !r_found) begin
            r_slot      <= r_pend_idx;
            r_hit_depth <= w_rdata[2*CB +: CB];
            r_hit_deep  <= w_rdata[CB +: CB];
            r_hit_unm   <= w_rdata[0 +: CB];
        end
        if (w_free) begin
            r_free_idx <= r_pend_idx;
        end
        if (i_cmd.commit) begin
            r_out_user <= {w_full, w_taken};
            r_out_data <= n_out_data;
        end
    end

    assign o_status.is_record = w_record;
    assign o_status.last_idx  = (r_idx == SW'(PROCESS_SLOTS - 1));
    assign o_status.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

/* hdl/per_process_call_depth_tracker.sv */
// Top level of the per-process call depth tracker.
// Depends on pcdt_pkg, pcdt_ctrl, pcdt_datapath (and pcdt_ram below it).
//
//  channel  | direction | carries
//  s (in)   | sink      | tdata: process_id; tuser: line_class, is_exit
//  m (out)  | source    | tdata: slot and per-process fields, global counters;
//           |           | tuser: event_taken, table_full
//
// A valid record passes through the scan state, where one slot of the table is read
// each cycle through the single read port of the slot RAM, then the drain state and
// the commit state. Any other line goes from the scan state straight to commit.
// Reset is synchronous and clears the used flags and counters; no clearing pass.
// The result waits in an output register; a stalled output holds the commit of
// the next item only.
module per_process_call_depth_tracker #(
    parameter int PROCESS_SLOTS = 16,
    parameter int COUNTER_BITS  = 32,
    parameter int PID_BITS      = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,   // [31:0] process_id
    input  logic [2:0]   i_s_tuser,   // [1:0] line_class, [2] is_exit
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [3:0] slot_number, [35:4] depth_now, [67:36] indent_level,
    // [99:68] deepest_depth, [131:100] unmatched_count, [163:132] records_count,
    // [195:164] skipped_count, [227:196] malformed_count,
    // [259:228] bad_version_count, [264:260] process_count, rest zero
    output logic [271:0] o_m_tdata,
    output logic [1:0]   o_m_tuser    // [0] event_taken, [1] table_full
);

    pcdt_pkg::t_ctl_cmd   w_cmd;
    pcdt_pkg::t_dp_status w_status;

    pcdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pcdt_datapath #(
        .PROCESS_SLOTS (PROCESS_SLOTS),
        .COUNTER_BITS  (COUNTER_BITS),
        .PID_BITS      (PID_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cmd      (w_cmd),
        .o_status   (w_status)
    );

endmodule
